[src/vtp_pkg.sv]
// Package for the vertex transform block: register indexes, field widths and constants.
// No dependencies.
`timescale 1ns / 1ps
package vtp_pkg;
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_ROW_X = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ROW_Z = 2'd2;
    localparam logic signed [15:0] HALF_W = 16'sd128;
    localparam logic signed [15:0] HALF_H = 16'sd128;
    localparam int StageCnt = 32; // one quotient bit per divider cell

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
        logic [31:0]        rem_x;  // magnitude remainder, shifting in dividend bits
        logic [31:0]        rem_y;
        logic [31:0]        num_x;  // dividend magnitude bits still to enter
        logic [31:0]        num_y;
        logic [15:0]        den;    // divisor magnitude
        logic [31:0]        q_x;
        logic [31:0]        q_y;
    } t_div;
endpackage

[src/vtp_div_cell.sv]
// One restoring-division cell: produces one quotient bit of x and y per cycle while enabled.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_div_cell import vtp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);
    t_div r_d, n_d;
    logic [32:0] w_rx, w_ry;

    always_comb begin
        n_d   = i_d;
        w_rx  = {i_d.rem_x, i_d.num_x[31]};
        w_ry  = {i_d.rem_y, i_d.num_y[31]};
        n_d.num_x = {i_d.num_x[30:0], 1'b0};
        n_d.num_y = {i_d.num_y[30:0], 1'b0};
        if (w_rx >= {17'd0, i_d.den}) begin
            n_d.rem_x = 32'(w_rx - {17'd0, i_d.den});
            n_d.q_x   = {i_d.q_x[30:0], 1'b1};
        end else begin
            n_d.rem_x = w_rx[31:0];
            n_d.q_x   = {i_d.q_x[30:0], 1'b0};
        end
        if (w_ry >= {17'd0, i_d.den}) begin
            n_d.rem_y = 32'(w_ry - {17'd0, i_d.den});
            n_d.q_y   = {i_d.q_y[30:0], 1'b1};
        end else begin
            n_d.rem_y = w_ry[31:0];
            n_d.q_y   = {i_d.q_y[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

[src/vtp_xform.sv]
// Matrix transform front end: two pipeline stages of products and sums.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_xform import vtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    input  logic [63:0]       i_row_x,
    input  logic [63:0]       i_row_y,
    input  logic [63:0]       i_row_z,
    output t_div              o_d
);
    logic signed [31:0] r_p0 [3], r_p1 [3], r_p2 [3];
    logic signed [15:0] r_t [3];
    logic               r_v1;
    t_div               r_d;
    logic [63:0]        w_row [3];
    logic signed [31:0] w_s [3];
    logic signed [31:0] w_xp, w_yp;
    logic signed [15:0] w_zp;
    logic [31:0]        w_mx, w_my;

    assign w_row[0] = i_row_x;
    assign w_row[1] = i_row_y;
    assign w_row[2] = i_row_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    // First stage: the three products of each row and the folded translation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [15:0] a, b, c, t, t0, t1;
                logic signed [31:0] ab;
                a  = w_row[i][15:0];
                b  = w_row[i][31:16];
                c  = w_row[i][47:32];
                t  = w_row[i][63:48];
                t0 = a + i_y;
                t1 = b + i_x;
                ab = a * b;
                r_p0[i] <= t0 * t1;
                r_p1[i] <= c * i_z;
                r_p2[i] <= i_x * i_y;
                r_t[i]  <= t - 16'(ab >>> 12);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) w_s[i] = r_p0[i] + r_p1[i] - r_p2[i];
        w_xp = (w_s[0] >>> 4) + $signed({{8{r_t[0][15]}}, r_t[0], 8'd0});
        w_yp = (w_s[1] >>> 4) + $signed({{8{r_t[1][15]}}, r_t[1], 8'd0});
        w_zp = 16'(w_s[2] >>> 12) + r_t[2];
        w_mx = w_xp[31] ? 32'(-w_xp) : w_xp;
        w_my = w_yp[31] ? 32'(-w_yp) : w_yp;
    end

    // Second stage: signs and magnitudes for the divider row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= r_v1;
            r_d.zero  <= (w_zp == 16'sd0);
            r_d.neg_x <= w_xp[31];
            r_d.neg_y <= w_yp[31];
            r_d.neg_z <= w_zp[15];
            r_d.rem_x <= '0;
            r_d.rem_y <= '0;
            r_d.num_x <= w_mx;
            r_d.num_y <= w_my;
            r_d.den   <= w_zp[15] ? 16'(-w_zp) : w_zp;
            r_d.q_x   <= '0;
            r_d.q_y   <= '0;
        end
    end

    assign o_d = r_d;
endmodule

[src/vertex_transform_project.sv]
// Top level of the vertex transform: configuration rows, transform stages,
// divider chain and output register. Depends on vtp_pkg, vtp_xform, vtp_div_cell.
`timescale 1ns / 1ps
// Takes one vertex per cycle while not stalled and returns one screen point per
// visible vertex. The transfer edge loads the first of 35 register stages, which
// are two transform stages, a row of 32 divider cells that each settle one
// quotient bit, and an output register that presents the point.
// Invisible vertices pass through as bubbles and produce no transfer. When the
// output is stalled the whole pipeline holds, so the input is stalled in every
// cycle in which a waiting result is stalled, however empty the pipeline is.
module vertex_transform_project import vtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_vertex_visible,
    input  logic signed [15:0] i_vert_x,
    input  logic signed [15:0] i_vert_y,
    input  logic signed [15:0] i_vert_z,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic              o_divide_error
);
    logic [63:0] r_row_x, r_row_y, r_row_z;
    logic        w_en;
    t_div        w_d [StageCnt+1];
    logic        r_valid;
    logic [31:0] w_qx, w_qy;
    logic        w_ovx, w_ovy;

    // The pipeline advances unless a finished result is waiting on a stall.
    assign w_en        = !(r_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= '0;
            r_row_y <= '0;
            r_row_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_X: r_row_x <= i_cfg_data;
                REG_ROW_Y: r_row_y <= i_cfg_data;
                REG_ROW_Z: r_row_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vtp_xform u_xform (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_valid && i_vertex_visible),
        .i_x(i_vert_x), .i_y(i_vert_y), .i_z(i_vert_z),
        .i_row_x(r_row_x), .i_row_y(r_row_y), .i_row_z(r_row_z),
        .o_d(w_d[0])
    );

    for (genvar g = 0; g < StageCnt; g++) begin : g_div
        vtp_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_d(w_d[g]), .o_d(w_d[g+1])
        );
    end

    always_comb begin
        t_div d;
        d     = w_d[StageCnt];
        w_qx  = (d.neg_x ^ d.neg_z) ? 32'(-d.q_x) : d.q_x;
        w_qy  = (d.neg_y ^ d.neg_z) ? 32'(-d.q_y) : d.q_y;
        w_ovx = (w_qx[31:15] != {17{w_qx[15]}});
        w_ovy = (w_qy[31:15] != {17{w_qy[15]}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_d[StageCnt].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_d[StageCnt].zero) begin
                o_screen_x     <= '0;
                o_screen_y     <= '0;
                o_divide_error <= 1'b1;
            end else begin
                o_screen_x     <= w_qx[15:0] + HALF_W;
                o_screen_y     <= w_qy[15:0] + HALF_H;
                o_divide_error <= w_ovx || w_ovy;
            end
        end
    end

    assign o_valid = r_valid;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_screen_x) && $stable(o_screen_y)
        && $stable(o_divide_error))
        else $error("result changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_screen_x, o_screen_y, o_divide_error}))
        else $error("unknown bits in a presented result");
endmodule
